### rtl/qmn_pkg.sv
// ----------------------------------------------------------------------------
// qmn_pkg
// Shared constants and types for the normalized quaternion product pipeline.
// ----------------------------------------------------------------------------
package qmn_pkg;

    localparam int QMN_WORD_BITS = 16;
    localparam int QMN_FRAC_BITS = 14;

    // the largest scaled component magnitude lands in [2^29, 2^30)
    localparam int SCALE_MSB  = 29;
    localparam int SCALE_BITS = 31;
    localparam int SHIFT_BITS = 6;
    localparam int SUMSQ_BITS = 64;
    localparam int ROOT_BITS  = 32;

    typedef struct packed {
        logic valid;
        logic zero;
    } qmn_ctl_t;

endpackage

### rtl/qmn_in_if.sv
// ----------------------------------------------------------------------------
// qmn_in_if
// Operand channel: two quaternions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qmn_in_if #(
    parameter int W = qmn_pkg::QMN_WORD_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_x;
    logic signed [W-1:0] a_y;
    logic signed [W-1:0] a_z;
    logic signed [W-1:0] a_w;
    logic signed [W-1:0] b_x;
    logic signed [W-1:0] b_y;
    logic signed [W-1:0] b_z;
    logic signed [W-1:0] b_w;

    modport source (output valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, input ready);
    modport sink   (input valid, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, output ready);
endinterface

### rtl/qmn_out_if.sv
// ----------------------------------------------------------------------------
// qmn_out_if
// Result channel: normalized quaternion and zero flag with valid/ready.
// ----------------------------------------------------------------------------
interface qmn_out_if #(
    parameter int W = qmn_pkg::QMN_WORD_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] prod_x;
    logic signed [W-1:0] prod_y;
    logic signed [W-1:0] prod_z;
    logic signed [W-1:0] prod_w;
    logic                zero_magnitude;

    modport source (output valid, prod_x, prod_y, prod_z, prod_w, zero_magnitude, input ready);
    modport sink   (input valid, prod_x, prod_y, prod_z, prod_w, zero_magnitude, output ready);
endinterface

### rtl/qmn_product.sv
// ----------------------------------------------------------------------------
// qmn_product
// Hamilton product: sixteen partial products, then the four signed sums.
// ----------------------------------------------------------------------------
module qmn_product #(
    parameter int WORD_BITS = qmn_pkg::QMN_WORD_BITS,
    parameter int PW        = 2 * WORD_BITS + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  qmn_pkg::qmn_ctl_t           ctl_in,
    input  logic signed [WORD_BITS-1:0] a [4],
    input  logic signed [WORD_BITS-1:0] b [4],
    output qmn_pkg::qmn_ctl_t           ctl_out,
    output logic signed [PW-1:0]        p_out [4]
);
    import qmn_pkg::*;

    localparam int G  = (2 * WORD_BITS > 62) ? 2 * WORD_BITS - 62 : 0;
    localparam int MW = 2 * WORD_BITS - G;

    function automatic logic signed [MW-1:0] mul(input logic signed [WORD_BITS-1:0] x,
                                                 input logic signed [WORD_BITS-1:0] y);
        logic signed [2*WORD_BITS-1:0] full;
        full = x * y;
        return MW'(full >>> G);
    endfunction

    logic signed [MW-1:0] m_next [16];
    logic signed [MW-1:0] m_reg  [16];
    qmn_ctl_t             c1_reg;
    qmn_ctl_t             c2_reg;
    logic signed [PW-1:0] p_reg  [4];

    // component order: x, y, z, w
    always_comb
    begin
        m_next[0]  = mul(a[1], b[2]);
        m_next[1]  = mul(a[2], b[1]);
        m_next[2]  = mul(a[0], b[3]);
        m_next[3]  = mul(b[0], a[3]);
        m_next[4]  = mul(a[2], b[0]);
        m_next[5]  = mul(a[0], b[2]);
        m_next[6]  = mul(a[1], b[3]);
        m_next[7]  = mul(b[1], a[3]);
        m_next[8]  = mul(a[0], b[1]);
        m_next[9]  = mul(a[1], b[0]);
        m_next[10] = mul(a[2], b[3]);
        m_next[11] = mul(b[2], a[3]);
        m_next[12] = mul(a[3], b[3]);
        m_next[13] = mul(a[0], b[0]);
        m_next[14] = mul(a[1], b[1]);
        m_next[15] = mul(a[2], b[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= ctl_in;
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_reg   <= m_next;
            p_reg[0] <= PW'(m_reg[0]) - PW'(m_reg[1]) + PW'(m_reg[2]) + PW'(m_reg[3]);
            p_reg[1] <= PW'(m_reg[4]) - PW'(m_reg[5]) + PW'(m_reg[6]) + PW'(m_reg[7]);
            p_reg[2] <= PW'(m_reg[8]) - PW'(m_reg[9]) + PW'(m_reg[10]) + PW'(m_reg[11]);
            p_reg[3] <= PW'(m_reg[12]) - PW'(m_reg[13]) - PW'(m_reg[14]) - PW'(m_reg[15]);
        end
    end

    assign ctl_out = c2_reg;
    assign p_out   = p_reg;
endmodule

### rtl/qmn_scale.sv
// ----------------------------------------------------------------------------
// qmn_scale
// Block scaling: find the leading one of the largest magnitude and shift
// all four sums by one power of two so that it lands in [2^29, 2^30).
// ----------------------------------------------------------------------------
module qmn_scale #(
    parameter int PW = 34
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  qmn_pkg::qmn_ctl_t                    ctl_in,
    input  logic signed [PW-1:0]                 p_in [4],
    output qmn_pkg::qmn_ctl_t                    ctl_out,
    output logic signed [qmn_pkg::SCALE_BITS-1:0] v_out [4]
);
    import qmn_pkg::*;

    localparam int PSW = $clog2(PW);

    qmn_ctl_t              ca_reg, cb_reg, cc_reg;
    logic signed [PW-1:0]  pa_reg [4];
    logic signed [PW-1:0]  pb_reg [4];
    logic [PW-1:0]         orr_next, orr_reg;
    logic [PSW-1:0]        pos;
    logic                  right_next, right_reg;
    logic [SHIFT_BITS-1:0] amt_next, amt_reg;
    logic signed [SCALE_BITS-1:0] v_next [4];
    logic signed [SCALE_BITS-1:0] v_reg  [4];
    logic [PW-1:0]         mag [4];

    // the leading one of the OR of all magnitudes is that of the largest one
    always_comb
    begin
        orr_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag[i]   = p_in[i][PW-1] ? PW'(-p_in[i]) : PW'(p_in[i]);
            orr_next = orr_next | mag[i];
        end
    end

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < PW; i++)
        begin
            if (orr_reg[i])
                pos = PSW'(i);
        end
        right_next = (int'(pos) > SCALE_MSB);
        amt_next   = right_next ? SHIFT_BITS'(int'(pos) - SCALE_MSB)
                                : SHIFT_BITS'(SCALE_MSB - int'(pos));
    end

    always_comb
    begin
        logic signed [63:0] ext;
        logic signed [63:0] sh;
        for (int i = 0; i < 4; i++)
        begin
            ext       = 64'(pb_reg[i]);
            sh        = right_reg ? (ext >>> amt_reg) : (ext <<< amt_reg);
            v_next[i] = sh[SCALE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0;
            cb_reg <= '0;
            cc_reg <= '0;
        end
        else if (adv)
        begin
            ca_reg <= '{valid: ctl_in.valid, zero: (orr_next == '0)};
            cb_reg <= ca_reg;
            cc_reg <= cb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg    <= p_in;
            orr_reg   <= orr_next;
            pb_reg    <= pa_reg;
            right_reg <= right_next;
            amt_reg   <= amt_next;
            v_reg     <= v_next;
        end
    end

    assign ctl_out = cc_reg;
    assign v_out   = v_reg;
endmodule

### rtl/qmn_sqrt.sv
// ----------------------------------------------------------------------------
// qmn_sqrt
// Sum of squares of the scaled components, then a pipelined integer square
// root that resolves one root bit per stage.
// ----------------------------------------------------------------------------
module qmn_sqrt (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   adv,
    input  qmn_pkg::qmn_ctl_t                      ctl_in,
    input  logic signed [qmn_pkg::SCALE_BITS-1:0]  v_in [4],
    output qmn_pkg::qmn_ctl_t                      ctl_out,
    output logic signed [qmn_pkg::SCALE_BITS-1:0]  v_out [4],
    output logic [qmn_pkg::ROOT_BITS-1:0]          root
);
    import qmn_pkg::*;

    localparam int NST = ROOT_BITS;
    localparam int RW  = ROOT_BITS + 3;

    qmn_ctl_t                    cq_reg, cs_reg;
    logic [2*SCALE_BITS-1:0]     sq_reg [4];
    logic signed [SCALE_BITS-1:0] vq_reg [4];
    logic [SUMSQ_BITS-1:0]       sum_reg;
    logic signed [SCALE_BITS-1:0] vs_reg [4];
    logic [SCALE_BITS-1:0]       mag [4];

    qmn_ctl_t                    c_st    [NST+1];
    logic [SUMSQ_BITS-1:0]       n_st    [NST+1];
    logic [RW-1:0]               rem_st  [NST+1];
    logic [ROOT_BITS-1:0]        root_st [NST+1];
    logic signed [SCALE_BITS-1:0] v_st   [NST+1][4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mag[i] = v_in[i][SCALE_BITS-1] ? SCALE_BITS'(-v_in[i]) : SCALE_BITS'(v_in[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cq_reg <= '0;
            cs_reg <= '0;
        end
        else if (adv)
        begin
            cq_reg <= ctl_in;
            cs_reg <= cq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= mag[i] * mag[i];
            vq_reg  <= v_in;
            sum_reg <= SUMSQ_BITS'(sq_reg[0]) + SUMSQ_BITS'(sq_reg[1])
                     + SUMSQ_BITS'(sq_reg[2]) + SUMSQ_BITS'(sq_reg[3]);
            vs_reg  <= vq_reg;
        end
    end

    assign c_st[0]    = cs_reg;
    assign n_st[0]    = sum_reg;
    assign rem_st[0]  = '0;
    assign root_st[0] = '0;
    assign v_st[0]    = vs_reg;

    for (genvar k = 0; k < NST; k++)
    begin : g_root
        logic [RW-1:0]        rem_in;
        logic [RW-1:0]        trial;
        logic [RW-1:0]        rem_next;
        logic [ROOT_BITS-1:0] root_next;

        // bring down the next bit pair and try a one in this root position
        always_comb
        begin
            rem_in = {rem_st[k][RW-3:0], n_st[k][SUMSQ_BITS-1-2*k -: 2]};
            trial  = {1'b0, root_st[k], 2'b01};
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = {root_st[k][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_in;
                root_next = {root_st[k][ROOT_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_st[k+1] <= '0;
            else if (adv)
                c_st[k+1] <= c_st[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_st[k+1]    <= n_st[k];
                rem_st[k+1]  <= rem_next;
                root_st[k+1] <= root_next;
                v_st[k+1]    <= v_st[k];
            end
        end
    end

    assign ctl_out = c_st[NST];
    assign v_out   = v_st[NST];
    assign root    = root_st[NST];
endmodule

### rtl/qmn_div.sv
// ----------------------------------------------------------------------------
// qmn_div
// Four-lane restoring divider: |v| * 2^FRAC_BITS / root, rounded half away
// from zero, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module qmn_div #(
    parameter int WORD_BITS = qmn_pkg::QMN_WORD_BITS,
    parameter int FRAC_BITS = qmn_pkg::QMN_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  qmn_pkg::qmn_ctl_t                     ctl_in,
    input  logic signed [qmn_pkg::SCALE_BITS-1:0] v_in [4],
    input  logic [qmn_pkg::ROOT_BITS-1:0]         root,
    output qmn_pkg::qmn_ctl_t                     ctl_out,
    output logic signed [WORD_BITS-1:0]           q_out [4]
);
    import qmn_pkg::*;

    localparam int NW  = FRAC_BITS + ROOT_BITS + 1;
    localparam int QW  = FRAC_BITS + 1;
    localparam int NST = FRAC_BITS + 1;
    localparam int CW  = ((QW > WORD_BITS) ? QW : WORD_BITS) + 1;

    qmn_ctl_t             c_st    [NST+1];
    logic [NW-1:0]        rem_st  [NST+1][4];
    logic [QW-1:0]        q_st    [NST+1][4];
    logic [3:0]           neg_st  [NST+1];
    logic [ROOT_BITS-1:0] r_st    [NST+1];

    qmn_ctl_t                    co_reg;
    logic signed [WORD_BITS-1:0] o_reg  [4];
    logic signed [WORD_BITS-1:0] o_next [4];
    logic [NW-1:0]               num    [4];
    logic [SCALE_BITS-1:0]       mag    [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = v_in[i][SCALE_BITS-1] ? SCALE_BITS'(-v_in[i]) : SCALE_BITS'(v_in[i]);
            num[i] = (NW'(mag[i]) << FRAC_BITS) + NW'(root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_st[0] <= '0;
        else if (adv)
            c_st[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rem_st[0][i]    <= num[i];
                q_st[0][i]      <= '0;
                neg_st[0][i]    <= v_in[i][SCALE_BITS-1];
            end
            r_st[0] <= root;
        end
    end

    for (genvar d = 0; d < NST; d++)
    begin : g_div
        localparam int J = FRAC_BITS - d;
        logic [NW-1:0] dv;
        logic [NW-1:0] rem_next [4];
        logic [QW-1:0] q_next   [4];

        always_comb
        begin
            dv = NW'(r_st[d]) << J;
            for (int i = 0; i < 4; i++)
            begin
                if (rem_st[d][i] >= dv)
                begin
                    rem_next[i] = rem_st[d][i] - dv;
                    q_next[i]   = q_st[d][i] | (QW'(1) << J);
                end
                else
                begin
                    rem_next[i] = rem_st[d][i];
                    q_next[i]   = q_st[d][i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                c_st[d+1] <= '0;
            else if (adv)
                c_st[d+1] <= c_st[d];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_st[d+1] <= rem_next;
                q_st[d+1]   <= q_next;
                neg_st[d+1] <= neg_st[d];
                r_st[d+1]   <= r_st[d];
            end
        end
    end

    // apply sign, saturate, and force zero output for a zero-length product
    always_comb
    begin
        logic [CW-1:0] qe;
        logic [CW-1:0] lim;
        for (int i = 0; i < 4; i++)
        begin
            qe  = CW'(q_st[NST][i]);
            lim = CW'(1) << (WORD_BITS - 1);
            if (c_st[NST].zero)
                o_next[i] = '0;
            else if (neg_st[NST][i])
                o_next[i] = (qe > lim) ? WORD_BITS'(lim) : WORD_BITS'(~qe + CW'(1));
            else
                o_next[i] = (qe > lim - CW'(1)) ? WORD_BITS'(lim - CW'(1)) : WORD_BITS'(qe);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            co_reg <= '0;
        else if (adv)
            co_reg <= c_st[NST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            o_reg <= o_next;
    end

    assign ctl_out = co_reg;
    assign q_out   = o_reg;
endmodule

### rtl/quaternion_multiply_normalize.sv
// Data path: product, scale, square root, divider; results are Q1.14 by default.
// Throughput: one item per cycle unless stalled; the square root resolves one bit
//   per stage, the divider one quotient bit per stage, every stage pipelined.
// A stalled result holds the whole pipeline in place; nothing is dropped.
// Reset (rst_n low, asynchronous) clears all valid bits; data regs are not reset.
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two fixed-point quaternions, scaled to unit length.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize #(
    parameter int WORD_BITS = qmn_pkg::QMN_WORD_BITS,
    parameter int FRAC_BITS = qmn_pkg::QMN_FRAC_BITS
) (
    input logic      clk,
    input logic      rst_n,
    qmn_in_if.sink   operand,
    qmn_out_if.source result
);
    import qmn_pkg::*;

    localparam int G  = (2 * WORD_BITS > 62) ? 2 * WORD_BITS - 62 : 0;
    localparam int PW = 2 * WORD_BITS - G + 2;

    logic                          adv;
    qmn_ctl_t                      c_in, c_prod, c_scale, c_sqrt, c_div;
    logic signed [WORD_BITS-1:0]   a [4];
    logic signed [WORD_BITS-1:0]   b [4];
    logic signed [PW-1:0]          p [4];
    logic signed [SCALE_BITS-1:0]  v_scale [4];
    logic signed [SCALE_BITS-1:0]  v_sqrt  [4];
    logic [ROOT_BITS-1:0]          root;
    logic signed [WORD_BITS-1:0]   q [4];

    // advance whenever the output register is empty or being drained
    assign adv           = !c_div.valid || result.ready;
    assign operand.ready = adv;

    assign c_in = '{valid: operand.valid, zero: 1'b0};
    assign a[0] = operand.a_x;
    assign a[1] = operand.a_y;
    assign a[2] = operand.a_z;
    assign a[3] = operand.a_w;
    assign b[0] = operand.b_x;
    assign b[1] = operand.b_y;
    assign b[2] = operand.b_z;
    assign b[3] = operand.b_w;

    qmn_product #(
        .WORD_BITS (WORD_BITS),
        .PW        (PW)
    ) u_product (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (c_in),
        .a       (a),
        .b       (b),
        .ctl_out (c_prod),
        .p_out   (p)
    );

    qmn_scale #(
        .PW (PW)
    ) u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (c_prod),
        .p_in    (p),
        .ctl_out (c_scale),
        .v_out   (v_scale)
    );

    qmn_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (c_scale),
        .v_in    (v_scale),
        .ctl_out (c_sqrt),
        .v_out   (v_sqrt),
        .root    (root)
    );

    qmn_div #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .ctl_in  (c_sqrt),
        .v_in    (v_sqrt),
        .root    (root),
        .ctl_out (c_div),
        .q_out   (q)
    );

    assign result.valid          = c_div.valid;
    assign result.zero_magnitude = c_div.zero;
    assign result.prod_x         = q[0];
    assign result.prod_y         = q[1];
    assign result.prod_z         = q[2];
    assign result.prod_w         = q[3];
endmodule

### rtl/qmn_checker.sv
// ----------------------------------------------------------------------------
// qmn_checker
// Port-level checks for the normalized quaternion product, bound to the top.
// ----------------------------------------------------------------------------
module qmn_checker #(
    parameter int W = qmn_pkg::QMN_WORD_BITS
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] px,
    input logic [W-1:0] py,
    input logic [W-1:0] pz,
    input logic [W-1:0] pw,
    input logic         zero
);
    // a pending result stays offered until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // the operand side moves exactly when the output register can move
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("operand ready out of step with result side");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero |-> px == '0 && py == '0 && pz == '0 && pw == '0)
        else $error("zero-length result with nonzero component");

    // a unit-length result always has some nonzero component
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero |-> px != '0 || py != '0 || pz != '0 || pw != '0)
        else $error("normalized result is all zero");
endmodule

bind quaternion_multiply_normalize qmn_checker #(
    .W (WORD_BITS)
) u_qmn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .px        (result.prod_x),
    .py        (result.prod_y),
    .pz        (result.prod_z),
    .pw        (result.prod_w),
    .zero      (result.zero_magnitude)
);
